// File: src/hpe_pkg.sv
// Shared types and constants for the histogram percentile engine.
// No dependencies; imported by the top, hpe_front, hpe_back and the bench.
`timescale 1ns / 1ps

package hpe_pkg;

   // Request kinds, coded as on the request tuser bus
   typedef enum logic [2:0] {
      OP_CLEAR = 3'd0,
      OP_RANGE = 3'd1,
      OP_BIN   = 3'd2,
      OP_PCT   = 3'd3,
      OP_BRT   = 3'd4
   } op_type;

   localparam int FUNC_W     = 3;
   localparam int SAMPLE_W   = 16;
   localparam int RATIO_W    = 17;
   localparam int LEVEL_W    = 16;
   localparam int VALUE_W    = 24;
   localparam int FRACTION_W = 17;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 1;

   localparam logic [RATIO_W-1:0]    RATIO_ONE = 17'h10000;
   localparam logic [FRACTION_W-1:0] FRAC_ONE  = 17'h10000;
   localparam logic [VALUE_W-1:0]    VALUE_MAX = 24'hFFFFFF;

   typedef struct packed {
      op_type                op;
      logic [SAMPLE_W-1:0]   sample;
      logic [RATIO_W-1:0]    ratio;
      logic [LEVEL_W-1:0]    level;
   } item_type;

endpackage

// File: src/histogram_percentile_engine.sv
// Histogram percentile engine: stream ports, front queue and back end.
// Depends on hpe_pkg, hpe_front, hpe_back.
`timescale 1ns / 1ps

// Collects a range pass and a bin pass over a pixel stream into a BINS-entry
// count memory, then answers percentile and brighter-than queries, one result
// per query. BINS must be a power of two. Requests pass a two-entry queue, so
// the sender and the back end stall independently. Work per request: a range
// sample updates the range registers directly; masked samples and unused codes
// are dropped in the queue; a bin sample runs one division on the shared
// one-bit-per-cycle divider of width D (49 at the default parameters), then a
// read and a write of its bin; a percentile query reads and checks each bin in
// turn up to the crossing bin, plus one division when the crossing bin is not
// empty; a brighter-than query reads and adds each bin from the start bin, plus
// up to two divisions. After reset and after every clear request the count
// memory is zeroed one entry per cycle, and no request is accepted during that pass.
module histogram_percentile_engine #(
   parameter int BINS        = 256,
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sample[15:0], ratio[32:16], level[48:33], zero fill above
   input  logic [hpe_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func[2:0], in_mask[3]
   input  logic [hpe_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // value[23:0], fraction[40:24], zero fill above
   output logic [hpe_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status[0]
   output logic [hpe_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import hpe_pkg::*;

   logic                  hold, q_valid, q_pop, rsp_status;
   item_type              q_item;
   logic [VALUE_W-1:0]    rsp_value;
   logic [FRACTION_W-1:0] rsp_fraction;

   hpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (req_tuser[2:0]),
      .req_mask   (req_tuser[3]),
      .req_sample (req_tdata[15:0]),
      .req_ratio  (req_tdata[32:16]),
      .req_level  (req_tdata[48:33]),
      .hold       (hold),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item)
   );

   hpe_back #(
      .BINS        (BINS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .clearing     (hold),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_value    (rsp_value),
      .rsp_fraction (rsp_fraction),
      .rsp_status   (rsp_status)
   );

   assign rsp_tdata = {{(RSP_DATA_W - VALUE_W - FRACTION_W){1'b0}}, rsp_fraction, rsp_value};
   assign rsp_tuser = rsp_status;

endmodule

// File: src/hpe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hpe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/hpe_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// No package dependencies.
`timescale 1ns / 1ps

module hpe_div #(
   parameter int DVD_W = 49,
   parameter int DVS_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/hpe_front.sv
// Request front end: classifies requests and queues the useful ones.
// Depends on hpe_pkg.
`timescale 1ns / 1ps

module hpe_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [hpe_pkg::FUNC_W-1:0]       req_func,
   input  logic                             req_mask,
   input  logic [hpe_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic [hpe_pkg::RATIO_W-1:0]      req_ratio,
   input  logic [hpe_pkg::LEVEL_W-1:0]      req_level,
   input  logic                             hold,
   output logic                             q_valid,
   input  logic                             q_pop,
   output hpe_pkg::item_type                q_item
);
   import hpe_pkg::*;

   item_type   entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       known, keep, push;
   item_type   item;

   // masked samples and unused codes never reach the back end
   always_comb begin
      known = (req_func == OP_CLEAR) || (req_func == OP_RANGE) || (req_func == OP_BIN) ||
              (req_func == OP_PCT) || (req_func == OP_BRT);
      keep  = known && !(((req_func == OP_RANGE) || (req_func == OP_BIN)) && !req_mask);
      item.op     = op_type'(req_func);
      item.sample = req_sample;
      item.ratio  = req_ratio;
      item.level  = req_level;
   end

   assign req_ready = (count_ff != 2'd2) && !hold;
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (q_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// File: src/hpe_back.sv
// Back end: statistics registers, bin store, query sequencer, result register.
// Depends on hpe_pkg, hpe_ram and hpe_div.
`timescale 1ns / 1ps

module hpe_back #(
   parameter int BINS        = 256,
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  hpe_pkg::item_type                q_item,
   output logic                             q_pop,
   output logic                             clearing,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [hpe_pkg::VALUE_W-1:0]      rsp_value,
   output logic [hpe_pkg::FRACTION_W-1:0]   rsp_fraction,
   output logic                             rsp_status
);
   import hpe_pkg::*;

   localparam int AW      = $clog2(BINS);
   localparam int IW      = $clog2(BINS + 1);
   localparam int VAL_W   = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int SUM_W   = COUNT_BITS + IW;
   localparam int THR_W   = COUNT_BITS + RATIO_W;
   localparam int POS_W   = IW + 17;
   localparam int PROD_W  = SAMPLE_BITS + POS_W;
   localparam int VX_RAW  = SAMPLE_BITS + 9;
   localparam int VX_W    = (VX_RAW > VALUE_W) ? VX_RAW : VALUE_W;
   localparam int DVD_A   = SUM_W + 16;
   localparam int DVD_W   = (DVD_A > PROD_W) ? DVD_A : PROD_W;
   localparam int DVS_A   = (SAMPLE_BITS + 1 > COUNT_BITS) ? SAMPLE_BITS + 1 : COUNT_BITS;
   localparam int DVS_W   = (DVS_A > IW + 8) ? DVS_A : IW + 8;
   // BINS is a power of two: scaling by BINS*256 is a shift
   localparam int PSH     = AW + 8;

   typedef enum logic [14:0] {
      S_CLEAR = 15'h0001,
      S_IDLE  = 15'h0002,
      S_BDIV  = 15'h0004,
      S_BRD   = 15'h0008,
      S_BWR   = 15'h0010,
      S_PRD   = 15'h0020,
      S_PCHK  = 15'h0040,
      S_PDIV  = 15'h0080,
      S_PMUL  = 15'h0100,
      S_PSCL  = 15'h0200,
      S_TDIV  = 15'h0400,
      S_TRD   = 15'h0800,
      S_TCHK  = 15'h1000,
      S_FDIV  = 15'h2000,
      S_OUT   = 15'h4000
   } state_type;

   state_type               state_ff, state_in;
   logic [SAMPLE_BITS-1:0]  low_ff, low_in;
   logic [SAMPLE_BITS-1:0]  high_ff, high_in;
   logic [COUNT_BITS-1:0]   total_ff, total_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [THR_W-1:0]        thr_ff, thr_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [VALUE_W-1:0]      pend_value_ff, pend_value_in;
   logic [FRACTION_W-1:0]   pend_frac_ff, pend_frac_in;
   logic                    pend_status_ff, pend_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [FRACTION_W-1:0]   rsp_frac_ff, rsp_frac_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic                    ram_wr_en, ram_rd_en;
   logic [AW-1:0]           ram_wr_addr, ram_rd_addr;
   logic [COUNT_BITS-1:0]   ram_wr_data, ram_rd_data;

   logic                    div_start, div_done;
   logic [DVD_W-1:0]        div_a, div_quo;
   logic [DVS_W-1:0]        div_b;

   logic [VAL_W-1:0]        samp_ext, lvl_ext, low_ext;
   logic [SAMPLE_BITS-1:0]  samp, span;
   logic                    flat;
   logic [RATIO_W-1:0]      ratio_c;
   logic [SUM_W-1:0]        sum_n;
   logic [DVD_W-1:0]        sum_sh, thr_x;
   logic [VX_W-1:0]         vx;

   hpe_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hpe_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      samp_ext = VAL_W'(q_item.sample);
      samp     = samp_ext[SAMPLE_BITS-1:0];
      lvl_ext  = VAL_W'(q_item.level);
      low_ext  = VAL_W'(low_ff);
      flat     = (high_ff <= low_ff);
      span     = flat ? '0 : (high_ff - low_ff);
      ratio_c  = (q_item.ratio > RATIO_ONE) ? RATIO_ONE : q_item.ratio;
      sum_n    = sum_ff + SUM_W'(ram_rd_data);
      sum_sh   = DVD_W'(sum_n) << 16;
      thr_x    = DVD_W'(thr_ff);
      vx       = '0;

      state_in       = state_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      total_in       = total_ff;
      idx_in         = idx_ff;
      sum_in         = sum_ff;
      thr_in         = thr_ff;
      pos_in         = pos_ff;
      prod_in        = prod_ff;
      pend_value_in  = pend_value_ff;
      pend_frac_in   = pend_frac_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_value_in   = rsp_value_ff;
      rsp_frac_in    = rsp_frac_ff;
      rsp_status_in  = rsp_status_ff;

      q_pop       = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[AW-1:0];
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[AW-1:0];
      div_start   = 1'b0;
      div_a       = '0;
      div_b       = '0;

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en = 1'b1;
            if (idx_ff == IW'(BINS - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop          = 1'b1;
               sum_in         = '0;
               pend_value_in  = '0;
               pend_frac_in   = '0;
               pend_status_in = 1'b0;
               case (q_item.op)
                  OP_CLEAR: begin
                     low_in   = '1;
                     high_in  = '0;
                     total_in = '0;
                     idx_in   = '0;
                     state_in = S_CLEAR;
                  end
                  OP_RANGE: begin
                     if (samp < low_ff) begin
                        low_in = samp;
                     end
                     if (samp > high_ff) begin
                        high_in = samp;
                     end
                     if (total_ff != '1) begin
                        total_in = total_ff + 1'b1;
                     end
                  end
                  OP_BIN: begin
                     if (!flat && samp >= low_ff && samp < high_ff) begin
                        div_start = 1'b1;
                        div_a     = DVD_W'(samp - low_ff) * DVD_W'(BINS);
                        div_b     = DVS_W'(span);
                        state_in  = S_BDIV;
                     end
                  end
                  OP_PCT: begin
                     if (total_ff == '0) begin
                        pend_status_in = 1'b1;
                        state_in       = S_OUT;
                     end else begin
                        thr_in   = THR_W'(total_ff) * THR_W'(ratio_c);
                        idx_in   = '0;
                        state_in = S_PRD;
                     end
                  end
                  OP_BRT: begin
                     if (total_ff == '0) begin
                        pend_status_in = 1'b1;
                        state_in       = S_OUT;
                     end else if (flat) begin
                        idx_in   = (lvl_ext <= low_ext) ? '0 : IW'(BINS);
                        state_in = S_TRD;
                     end else if (lvl_ext <= low_ext) begin
                        idx_in   = '0;
                        state_in = S_TRD;
                     end else begin
                        // round half up: (2*num + den) / (2*den)
                        div_start = 1'b1;
                        div_a     = ((DVD_W'(lvl_ext - low_ext) * DVD_W'(BINS)) << 1)
                                    + DVD_W'(span);
                        div_b     = DVS_W'(span) << 1;
                        state_in  = S_TDIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BDIV: begin
            if (div_done) begin
               if (div_quo < DVD_W'(BINS)) begin
                  idx_in   = IW'(div_quo);
                  state_in = S_BRD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_BRD: begin
            ram_rd_en = 1'b1;
            state_in  = S_BWR;
         end
         S_BWR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + 1'b1;
            state_in    = S_IDLE;
         end
         S_PRD: begin
            ram_rd_en = 1'b1;
            state_in  = S_PCHK;
         end
         S_PCHK: begin
            sum_in = sum_n;
            if (sum_sh >= thr_x) begin
               if (ram_rd_data == '0) begin
                  pos_in   = POS_W'(idx_ff) << 16;
                  state_in = S_PMUL;
               end else begin
                  div_start = 1'b1;
                  div_a     = sum_sh - thr_x;
                  div_b     = DVS_W'(ram_rd_data);
                  state_in  = S_PDIV;
               end
            end else if (idx_ff == IW'(BINS - 1)) begin
               // threshold never reached: answer is the top of the range
               vx            = VX_W'(high_ff) << 8;
               pend_value_in = (vx > VX_W'(VALUE_MAX)) ? VALUE_MAX : VALUE_W'(vx);
               state_in      = S_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_PRD;
            end
         end
         S_PDIV: begin
            if (div_done) begin
               // interpolate down from the bin's upper edge
               pos_in   = (POS_W'(idx_ff + 1'b1) << 16) - POS_W'(div_quo[16:0]);
               state_in = S_PMUL;
            end
         end
         S_PMUL: begin
            prod_in  = PROD_W'(span) * PROD_W'(pos_ff);
            state_in = S_PSCL;
         end
         S_PSCL: begin
            vx            = (VX_W'(low_ff) << 8) + VX_W'(prod_ff >> PSH);
            pend_value_in = (vx > VX_W'(VALUE_MAX)) ? VALUE_MAX : VALUE_W'(vx);
            state_in      = S_OUT;
         end
         S_TDIV: begin
            if (div_done) begin
               idx_in   = (div_quo > DVD_W'(BINS)) ? IW'(BINS) : IW'(div_quo);
               state_in = S_TRD;
            end
         end
         S_TRD: begin
            if (idx_ff == IW'(BINS)) begin
               div_start = 1'b1;
               div_a     = DVD_W'(sum_ff) << 16;
               div_b     = DVS_W'(total_ff);
               state_in  = S_FDIV;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_TCHK;
            end
         end
         S_TCHK: begin
            sum_in   = sum_n;
            idx_in   = idx_ff + 1'b1;
            state_in = S_TRD;
         end
         S_FDIV: begin
            if (div_done) begin
               pend_frac_in = (div_quo > DVD_W'(FRAC_ONE)) ? FRAC_ONE
                                                           : FRACTION_W'(div_quo);
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_value_ff;
               rsp_frac_in   = pend_frac_ff;
               rsp_status_in = pend_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         low_ff       <= '1;
         high_ff      <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff         <= sum_in;
      thr_ff         <= thr_in;
      pos_ff         <= pos_in;
      prod_ff        <= prod_in;
      pend_value_ff  <= pend_value_in;
      pend_frac_ff   <= pend_frac_in;
      pend_status_ff <= pend_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_frac_ff    <= rsp_frac_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign clearing     = (state_ff == S_CLEAR);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_fraction = rsp_frac_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// File: dv/hpe_checker.sv
// Checker for the histogram percentile engine: watches both stream channels,
// keeps its own copy of the histogram state and compares every response.
// Depends on hpe_pkg.
`timescale 1ns / 1ps

module hpe_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [hpe_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [hpe_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [hpe_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [hpe_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output int                              fail_count,
   output int                              pending
);
   import hpe_pkg::*;

   localparam int NBINS = 256;
   localparam longint unsigned COUNT_TOP = (64'd1 << 24) - 1;
   localparam longint unsigned SAMPLE_TOP = 64'hFFFF;

   typedef struct {
      logic [VALUE_W-1:0]    value;
      logic [FRACTION_W-1:0] fraction;
      logic                  status;
   } stat_rsp_type;

   longint unsigned hist[NBINS];
   longint unsigned lo_pix, hi_pix, pix_total;
   stat_rsp_type awaited[$];

   function automatic void clear_stats();
      for (int i = 0; i < NBINS; i++) hist[i] = 0;
      lo_pix = SAMPLE_TOP;
      hi_pix = 0;
      pix_total = 0;
   endfunction

   function automatic longint unsigned bump(longint unsigned v);
      return (v < COUNT_TOP) ? v + 1 : COUNT_TOP;
   endfunction

   function automatic longint unsigned pct_value(longint unsigned r);
      longint unsigned thr, acc, pos, span;
      if (r > 65536) r = 65536;
      thr = pix_total * r;
      span = (hi_pix > lo_pix) ? hi_pix - lo_pix : 0;
      acc = 0;
      for (int i = 0; i < NBINS; i++) begin
         acc += hist[i];
         if ((acc << 16) >= thr) begin
            if (hist[i] == 0) pos = longint'(i) << 16;
            else pos = (longint'(i + 1) << 16) - (((acc << 16) - thr) / hist[i]);
            return (lo_pix << 8) + (span * pos) / (NBINS * 256);
         end
      end
      return hi_pix << 8;
   endfunction

   function automatic longint unsigned brighter_share(longint unsigned lvl);
      longint unsigned first, acc, num, den, f;
      if (hi_pix <= lo_pix) first = (lvl <= lo_pix) ? 0 : NBINS;
      else if (lvl <= lo_pix) first = 0;
      else begin
         num = (lvl - lo_pix) * NBINS;
         den = hi_pix - lo_pix;
         first = (2 * num + den) / (2 * den);
         if (first > NBINS) first = NBINS;
      end
      acc = 0;
      for (longint unsigned i = first; i < NBINS; i++) acc += hist[i];
      f = (acc << 16) / pix_total;
      return (f > 65536) ? 65536 : f;
   endfunction

   function automatic void apply_request(logic [2:0] fn, longint unsigned smp, logic msk,
                                         longint unsigned rat, longint unsigned lvl);
      stat_rsp_type r;
      longint unsigned idx, v;
      r.value = '0;
      r.fraction = '0;
      r.status = 1'b0;
      case (fn)
         OP_CLEAR: clear_stats();
         OP_RANGE: if (msk) begin
            if (smp < lo_pix) lo_pix = smp;
            if (smp > hi_pix) hi_pix = smp;
            pix_total = bump(pix_total);
         end
         OP_BIN: if (msk && hi_pix > lo_pix && smp >= lo_pix && smp < hi_pix) begin
            idx = ((smp - lo_pix) * NBINS) / (hi_pix - lo_pix);
            if (idx < NBINS) hist[idx] = bump(hist[idx]);
         end
         OP_PCT, OP_BRT: begin
            if (pix_total == 0) r.status = 1'b1;
            else if (fn == OP_PCT) begin
               v = pct_value(rat);
               r.value = (v > VALUE_MAX) ? VALUE_MAX : v[VALUE_W-1:0];
            end else r.fraction = FRACTION_W'(brighter_share(lvl));
            awaited.insert(awaited.size(), r);
         end
         default: ;
      endcase
   endfunction

   initial begin
      clear_stats();
   end

   always @(posedge clock) begin
      stat_rsp_type want;
      if (reset) begin
         fail_count = 0;
         clear_stats();
         awaited.delete();
      end else begin
         if (req_tvalid && req_tready)
            apply_request(req_tuser[2:0], req_tdata[15:0], req_tuser[3],
                          req_tdata[32:16], req_tdata[48:33]);
         if (rsp_tvalid && rsp_tready) begin
            if (awaited.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response value=%h fraction=%h status=%b",
                        $realtime, rsp_tdata[23:0], rsp_tdata[40:24], rsp_tuser[0]);
            end else begin
               want = awaited.pop_front();
               if (rsp_tdata[23:0] !== want.value || rsp_tdata[40:24] !== want.fraction ||
                   rsp_tuser[0] !== want.status) begin
                  fail_count++;
                  $display("%0t: mismatch expected value=%h fraction=%h status=%b",
                           $realtime, want.value, want.fraction, want.status);
                  $display("%0t:          actual   value=%h fraction=%h status=%b",
                           $realtime, rsp_tdata[23:0], rsp_tdata[40:24], rsp_tuser[0]);
               end
            end
         end
      end
      pending <= awaited.size();
   end

endmodule

// File: dv/testbench.sv
// Top of the histogram percentile engine bench: clock, reset, request
// stimulus, response back-pressure and verdict. Depends on hpe_pkg,
// histogram_percentile_engine and hpe_checker.
`timescale 1ns / 1ps

module testbench;
   import hpe_pkg::*;

   localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
   localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI  = 3'd7;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int ITEM_GOAL = 1950;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   int fail_count, pending;
   int send_idle = 0, rsp_stall = 0;
   int items_sent = 0;
   int hold_left = 0;
   logic hold_go = 0, hold_done = 0;
   int quiet_cycles = 0;

   always #2 clock = ~clock;

   histogram_percentile_engine dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   hpe_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .pending
   );

   // response side; one long hold-off on request from the stimulus
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 0;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_tready <= 0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // fields are narrowed to their bus widths here
   task automatic send_req(int fn, int smp, int msk, int rat, int lvl);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'd0, 16'(lvl), 17'(rat), 16'(smp)};
      req_tuser <= {1'(msk), 3'(fn)};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_noise();
      send_req($urandom_range(FUNC_SPARE_HI, 0), $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      int base, span, nr, nb, nq, seq;
      repeat (10) @(posedge clock);
      reset <= 0;

      // fresh state: both queries report no pixels
      send_req(OP_PCT, 0, 1, RATIO_ONE, 0);
      send_req(OP_BRT, 0, 1, 0, 16'hFFFF);
      send_req(FUNC_SPARE_LO, 16'h1234, 1, 0, 0);
      send_req(FUNC_SPARE_MID, 16'hFFFF, 1, 17'h1FFFF, 16'hFFFF);
      send_req(FUNC_SPARE_HI, 0, 0, 0, 0);
      send_req(OP_RANGE, 1000, 1, 0, 0);
      send_req(OP_RANGE, 5000, 1, 0, 0);
      send_req(OP_RANGE, 65535, 0, 0, 0);
      // percentile with empty bins
      send_req(OP_PCT, 0, 1, 0, 0);
      send_req(OP_PCT, 0, 1, 40000, 0);
      send_req(OP_BIN, 1000, 1, 0, 0);
      send_req(OP_BIN, 4999, 1, 0, 0);
      send_req(OP_BIN, 5000, 1, 0, 0);
      send_req(OP_BIN, 500, 1, 0, 0);
      send_req(OP_BIN, 3000, 0, 0, 0);
      send_req(OP_BIN, 3000, 1, 0, 0);
      send_req(OP_PCT, 0, 1, 32768, 0);
      send_req(OP_PCT, 0, 1, 17'h1FFFF, 0);
      send_req(OP_BRT, 0, 1, 0, 0);
      send_req(OP_BRT, 0, 1, 0, 4990);
      // flat range
      send_req(OP_CLEAR, 0, 0, 0, 0);
      send_req(OP_RANGE, 7, 1, 0, 0);
      send_req(OP_BIN, 7, 1, 0, 0);
      send_req(OP_BRT, 0, 1, 0, 7);
      send_req(OP_BRT, 0, 1, 0, 8);

      // receiver holds off while queries keep coming
      hold_go <= 1;
      for (int k = 0; k < 8; k++) send_req(OP_PCT, 0, 1, $urandom_range(0, 65536), 0);

      seq = 0;
      while (items_sent < ITEM_GOAL) begin
         case ((seq / 6) % 4)
            0: begin send_idle = 0; rsp_stall = 0; end
            1: begin send_idle = 56; rsp_stall = 0; end
            2: begin send_idle = 0; rsp_stall = 56; end
            default: begin send_idle = 30; rsp_stall = 30; end
         endcase
         seq++;
         if ($urandom_range(9) < 8) send_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
         base = $urandom_range(0, 65535);
         span = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
         nr = $urandom_range(1, 10);
         nb = $urandom_range(1, 14);
         nq = $urandom_range(1, 4);
         for (int k = 0; k < nr; k++)
            send_req(OP_RANGE, base + $urandom_range(0, span), $urandom_range(9) != 0,
                     $urandom, $urandom);
         for (int r = 0; r <= ($urandom_range(4) == 0); r++)
            for (int k = 0; k < nb; k++)
               send_req(OP_BIN, base + $urandom_range(0, span + 2) - 1,
                        $urandom_range(9) != 0, $urandom, $urandom);
         for (int k = 0; k < nq; k++) begin
            if ($urandom_range(1))
               send_req(OP_PCT, $urandom, $urandom,
                        ($urandom_range(4) == 0) ? $urandom_range(0, 131071)
                                                 : $urandom_range(0, 65536), $urandom);
            else
               send_req(OP_BRT, $urandom, $urandom, $urandom,
                        ($urandom_range(4) == 0) ? $urandom_range(0, 65535)
                                                 : base + $urandom_range(0, span + 2) - 1);
         end
         if ($urandom_range(4) == 0) send_noise();
      end

      req_tvalid <= 0;
      send_idle = 0;
      rsp_stall = 0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
